// File: design/assert_macros.svh
// Assertion helpers for the duration parser design.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define DSP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("duration parser assertion failed");

// The expression must never be true out of reset.
`define DSP_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("duration parser forbidden condition seen");

`endif

// File: design/dsp_pkg.sv
package dsp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_APPROX   = 3'd1,
        ST_BAD_UNIT = 3'd2,
        ST_BAD_NUM  = 3'd3,
        ST_RANGE    = 3'd4
    } status_t;

    // Magnitude saturates here (2^32, always out of range)
    localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;

    // Unit multipliers in seconds
    localparam int          MULT_W     = 25;
    localparam logic [24:0] SECS_ONE   = 25'd1;
    localparam logic [24:0] SECS_MIN   = 25'd60;
    localparam logic [24:0] SECS_HOUR  = 25'(60 * 60);
    localparam logic [24:0] SECS_DAY   = 25'(24 * 60 * 60);
    localparam logic [24:0] SECS_WEEK  = 25'(7 * 24 * 60 * 60);
    localparam logic [24:0] SECS_MONTH = 25'(31 * 24 * 60 * 60);
    localparam logic [24:0] SECS_YEAR  = 25'(365 * 24 * 60 * 60);

    // Signed 32-bit range limits on the magnitude
    localparam logic [31:0] LIMIT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] LIMIT_NEG = 32'h8000_0000;

    // ASCII codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_UP_M  = 8'h4D;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_UP_T  = 8'h54;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_UP_Y  = 8'h59;
    localparam logic [7:0] CH_LO_D  = 8'h64;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_M  = 8'h6D;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_LO_W  = 8'h77;

endpackage

// File: design/dsp_if.sv
// Character stream: one character per beat, is_last on the final one
interface dsp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       is_last;

    modport source (output valid, output text_char, output is_last, input ready);
    modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

// Result stream: one beat per string
interface dsp_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seconds;
    logic        [2:0]  status;

    modport source (output valid, output seconds, output status, input ready);
    modport sink   (input valid, input seconds, input status, output ready);
endinterface

// Mode register write channel
interface dsp_cfg_if;
    logic valid;
    logic ready;
    logic duration_mode;

    modport source (output valid, output duration_mode, input ready);
    modport sink   (input valid, input duration_mode, output ready);
endinterface

// File: design/duration_string_parser_unit.sv
// Interval string parser. Characters arrive one per beat on char_in, the last
// one flagged by is_last; the string's length in seconds and a status leave on
// result. One character is taken every cycle unless a stall holds char_in off:
// each beat only updates a small parse state (sign and prefix flags, a
// saturating decimal accumulator and a length count). The final character
// loads a three-stage result pipeline (unit decode, 32x25 multiply, range check
// and sign), so a result passes the decode, product and output registers in
// turn, and the next string can start while it is still in the pipeline. A stall
// on result backs up through the pipeline registers before char_in is held off.
// The mode register (0 plain lower-case suffix, 1 duration form with P/T
// prefixes) should be written between strings.
module duration_string_parser_unit
    import dsp_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    dsp_char_if.sink   char_in,
    dsp_res_if.source  result,
    dsp_cfg_if.sink    cfg
);

`include "assert_macros.svh"

    localparam logic [5:0] COUNT_LIMIT = 6'(BUFFER_BYTES - 1);
    localparam logic [5:0] COUNT_MAX   = 6'd63;

    typedef enum logic [1:0] {
        PFX_SIGN,
        PFX_P,
        PFX_T,
        PFX_NUM
    } prefix_t;

    // Parse state
    logic        mode_reg;
    prefix_t     stage_reg, stage_next;
    logic        neg_reg, neg_next;
    logic        tsf_reg, tsf_next;
    logic        sign_reg, sign_next;
    logic        sseen_reg, sseen_next;
    logic [32:0] acc_reg, acc_next;
    logic        inv_reg, inv_next;
    logic        dseen_reg, dseen_next;
    logic [5:0]  cnt_reg, cnt_next;

    // Decode stage
    logic              b_valid_reg;
    logic              b_err_reg;
    status_t           b_status_reg;
    logic [31:0]       b_acc_reg;
    logic              b_big_reg;
    logic [MULT_W-1:0] b_mult_reg;
    logic              b_neg_reg;
    logic              b_approx_reg;

    // Product stage
    logic        c_valid_reg;
    logic        c_err_reg;
    status_t     c_status_reg;
    logic [56:0] c_prod_reg;
    logic        c_big_reg;
    logic        c_neg_reg;
    logic        c_approx_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [31:0] out_secs_reg, out_secs_next;
    status_t            out_status_reg, out_status_next;

    logic        accept;
    logic        b_ready, c_ready;
    logic        is_digit;
    logic [3:0]  digit;
    logic [36:0] acc_x10;
    logic        num_char;

    // Effective state seen by the final character
    logic        eff_neg, eff_tsf, eff_sign, eff_inv, eff_dseen;
    logic [32:0] eff_acc;
    logic [5:0]  eff_cnt;

    // Unit decode of the final character
    logic [MULT_W-1:0] unit_mult;
    logic              unit_bad, unit_approx;
    logic              fin_err;
    status_t           fin_status;

    logic [56:0] prod_full;
    logic [31:0] limit;

    // Handshake: each stage advances when the next one is free
    assign c_ready       = !out_valid_reg || result.ready;
    assign b_ready       = !c_valid_reg || c_ready;
    assign char_in.ready = !b_valid_reg || b_ready;
    assign accept        = char_in.valid && char_in.ready;
    assign cfg.ready     = 1'b1;

    assign result.valid   = out_valid_reg;
    assign result.seconds = out_secs_reg;
    assign result.status  = out_status_reg;

    assign is_digit = (char_in.text_char >= CH_0) && (char_in.text_char <= CH_9);
    assign digit    = 4'(char_in.text_char - CH_0);
    assign acc_x10  = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 37'(digit);

    // Body character: prefix skipping, then number syntax
    always_comb
    begin
        stage_next = stage_reg;
        neg_next   = neg_reg;
        tsf_next   = tsf_reg;
        sign_next  = sign_reg;
        sseen_next = sseen_reg;
        acc_next   = acc_reg;
        inv_next   = inv_reg;
        dseen_next = dseen_reg;
        cnt_next   = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 6'd1;
        num_char   = 1'b1;

        if (mode_reg)
        begin
            case (stage_reg)
                PFX_SIGN:
                begin
                    if (char_in.text_char == CH_MINUS)
                    begin
                        neg_next   = 1'b1;
                        stage_next = PFX_P;
                        num_char   = 1'b0;
                    end
                    else if (char_in.text_char == CH_UP_P)
                    begin
                        stage_next = PFX_T;
                        num_char   = 1'b0;
                    end
                    else if (char_in.text_char == CH_UP_T)
                    begin
                        tsf_next   = 1'b1;
                        stage_next = PFX_NUM;
                        num_char   = 1'b0;
                    end
                    else
                    begin
                        stage_next = PFX_NUM;
                    end
                end
                PFX_P:
                begin
                    if (char_in.text_char == CH_UP_P)
                    begin
                        stage_next = PFX_T;
                        num_char   = 1'b0;
                    end
                    else if (char_in.text_char == CH_UP_T)
                    begin
                        tsf_next   = 1'b1;
                        stage_next = PFX_NUM;
                        num_char   = 1'b0;
                    end
                    else
                    begin
                        stage_next = PFX_NUM;
                    end
                end
                PFX_T:
                begin
                    stage_next = PFX_NUM;
                    if (char_in.text_char == CH_UP_T)
                    begin
                        tsf_next = 1'b1;
                        num_char = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (num_char)
        begin
            if (is_digit)
            begin
                acc_next   = (acc_x10 > 37'(MAG_CAP)) ? MAG_CAP : acc_x10[32:0];
                dseen_next = 1'b1;
            end
            else if (char_in.text_char == CH_PLUS || char_in.text_char == CH_MINUS)
            begin
                if (dseen_reg || sseen_reg)
                begin
                    inv_next = 1'b1;
                end
                else
                begin
                    sseen_next = 1'b1;
                    sign_next  = (char_in.text_char == CH_MINUS);
                end
            end
            else
            begin
                inv_next = 1'b1;
            end
        end
    end

    // A final digit is part of the number; any other final character is the unit
    assign eff_neg   = is_digit ? neg_next   : neg_reg;
    assign eff_tsf   = is_digit ? tsf_next   : tsf_reg;
    assign eff_sign  = is_digit ? sign_next  : sign_reg;
    assign eff_inv   = is_digit ? inv_next   : inv_reg;
    assign eff_dseen = is_digit ? dseen_next : dseen_reg;
    assign eff_acc   = is_digit ? acc_next   : acc_reg;
    assign eff_cnt   = is_digit ? cnt_next   : cnt_reg;

    // Unit decode
    always_comb
    begin
        unit_mult   = SECS_ONE;
        unit_bad    = 1'b0;
        unit_approx = 1'b0;
        if (!is_digit)
        begin
            if (!mode_reg)
            begin
                case (char_in.text_char)
                    CH_LO_S: unit_mult = SECS_ONE;
                    CH_LO_M: unit_mult = SECS_MIN;
                    CH_LO_H: unit_mult = SECS_HOUR;
                    CH_LO_D: unit_mult = SECS_DAY;
                    CH_LO_W: unit_mult = SECS_WEEK;
                    default: unit_bad  = 1'b1;
                endcase
            end
            else
            begin
                case (char_in.text_char)
                    CH_UP_S: unit_mult = SECS_ONE;
                    CH_UP_M:
                    begin
                        unit_mult   = eff_tsf ? SECS_MIN : SECS_MONTH;
                        unit_approx = !eff_tsf;
                    end
                    CH_UP_H: unit_mult = SECS_HOUR;
                    CH_UP_D: unit_mult = SECS_DAY;
                    CH_UP_W: unit_mult = SECS_WEEK;
                    CH_UP_Y:
                    begin
                        unit_mult   = SECS_YEAR;
                        unit_approx = 1'b1;
                    end
                    default: unit_bad = 1'b1;
                endcase
            end
        end
    end

    // Early status: bad unit, then too long, then bad number
    always_comb
    begin
        fin_err    = 1'b1;
        fin_status = ST_OK;
        if (unit_bad)
        begin
            fin_status = ST_BAD_UNIT;
        end
        else if (eff_cnt > COUNT_LIMIT)
        begin
            fin_status = ST_RANGE;
        end
        else if (eff_inv || !eff_dseen)
        begin
            fin_status = ST_BAD_NUM;
        end
        else
        begin
            fin_err    = 1'b0;
            fin_status = unit_approx ? ST_APPROX : ST_OK;
        end
    end

    // Multiply
    assign prod_full = {25'b0, b_acc_reg} * {32'b0, b_mult_reg};

    // Range check and sign
    assign limit = c_neg_reg ? LIMIT_NEG : LIMIT_POS;

    always_comb
    begin
        out_secs_next   = 32'sd0;
        out_status_next = c_status_reg;
        if (!c_err_reg)
        begin
            if (c_big_reg || (c_prod_reg > {25'b0, limit}))
            begin
                out_status_next = ST_RANGE;
            end
            else if (c_neg_reg)
            begin
                out_secs_next = $signed(32'd0 - c_prod_reg[31:0]);
            end
            else
            begin
                out_secs_next = $signed(c_prod_reg[31:0]);
            end
        end
    end

    // All registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            stage_reg      <= PFX_SIGN;
            neg_reg        <= 1'b0;
            tsf_reg        <= 1'b0;
            sign_reg       <= 1'b0;
            sseen_reg      <= 1'b0;
            acc_reg        <= '0;
            inv_reg        <= 1'b0;
            dseen_reg      <= 1'b0;
            cnt_reg        <= '0;
            b_valid_reg    <= 1'b0;
            b_err_reg      <= 1'b0;
            b_status_reg   <= ST_OK;
            b_acc_reg      <= '0;
            b_big_reg      <= 1'b0;
            b_mult_reg     <= '0;
            b_neg_reg      <= 1'b0;
            b_approx_reg   <= 1'b0;
            c_valid_reg    <= 1'b0;
            c_err_reg      <= 1'b0;
            c_status_reg   <= ST_OK;
            c_prod_reg     <= '0;
            c_big_reg      <= 1'b0;
            c_neg_reg      <= 1'b0;
            c_approx_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_secs_reg   <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            if (cfg.valid)
            begin
                mode_reg <= cfg.duration_mode;
            end

            // Parse state: update on body beats, clear after the final beat
            if (accept && !char_in.is_last)
            begin
                stage_reg <= stage_next;
                neg_reg   <= neg_next;
                tsf_reg   <= tsf_next;
                sign_reg  <= sign_next;
                sseen_reg <= sseen_next;
                acc_reg   <= acc_next;
                inv_reg   <= inv_next;
                dseen_reg <= dseen_next;
                cnt_reg   <= cnt_next;
            end
            else if (accept)
            begin
                stage_reg <= PFX_SIGN;
                neg_reg   <= 1'b0;
                tsf_reg   <= 1'b0;
                sign_reg  <= 1'b0;
                sseen_reg <= 1'b0;
                acc_reg   <= '0;
                inv_reg   <= 1'b0;
                dseen_reg <= 1'b0;
                cnt_reg   <= '0;
            end

            // Decode stage
            if (accept && char_in.is_last)
            begin
                b_valid_reg  <= 1'b1;
                b_err_reg    <= fin_err;
                b_status_reg <= fin_status;
                b_acc_reg    <= eff_acc[31:0];
                b_big_reg    <= eff_acc[32];
                b_mult_reg   <= unit_mult;
                b_neg_reg    <= eff_neg != eff_sign;
                b_approx_reg <= unit_approx;
            end
            else if (b_ready)
            begin
                b_valid_reg <= 1'b0;
            end

            // Product stage
            if (b_ready)
            begin
                c_valid_reg <= b_valid_reg;
                if (b_valid_reg)
                begin
                    c_err_reg    <= b_err_reg;
                    c_status_reg <= b_status_reg;
                    c_prod_reg   <= prod_full;
                    c_big_reg    <= b_big_reg;
                    c_neg_reg    <= b_neg_reg;
                    c_approx_reg <= b_approx_reg;
                end
            end

            // Output register
            if (c_ready)
            begin
                out_valid_reg <= c_valid_reg;
                if (c_valid_reg)
                begin
                    out_secs_reg   <= out_secs_next;
                    out_status_reg <= (!c_err_reg && out_status_next != ST_RANGE)
                                      ? (c_approx_reg ? ST_APPROX : ST_OK)
                                      : out_status_next;
                end
            end
        end
    end

    // Checks
    `DSP_ASSERT(a_err_zero, result.valid && (result.status == ST_BAD_UNIT || result.status == ST_BAD_NUM || result.status == ST_RANGE) |-> result.seconds == 32'sd0)
    `DSP_ASSERT(a_clear_after_last, accept && char_in.is_last |=> cnt_reg == 6'd0 && !dseen_reg && !inv_reg)
    `DSP_ASSERT(a_last_loads, accept && char_in.is_last |=> b_valid_reg)
    `DSP_NEVER(a_acc_cap, acc_reg > MAG_CAP)

endmodule

// File: verif/interval_checker.sv
`timescale 1ns / 1ps

// Watches the character, result and mode-write channels, predicts each result
// from the characters taken and compares it with what the parser returns.
module interval_checker
    import dsp_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    dsp_char_if         chars,
    dsp_res_if          res,
    dsp_cfg_if          cfg,
    output int unsigned mismatches,
    output int unsigned in_flight,
    output int unsigned compared
);

    typedef struct packed {
        logic signed [31:0] seconds;
        status_t            status;
    } interval_t;

    // Characters the parser gives meaning to
    localparam logic [7:0] C_PLUS  = "+";
    localparam logic [7:0] C_MINUS = "-";
    localparam logic [7:0] C_0     = "0";
    localparam logic [7:0] C_9     = "9";
    localparam logic [7:0] C_P     = "P";
    localparam logic [7:0] C_T     = "T";
    localparam logic [7:0] U_SEC   = "S";
    localparam logic [7:0] U_MIN   = "M";
    localparam logic [7:0] U_HOUR  = "H";
    localparam logic [7:0] U_DAY   = "D";
    localparam logic [7:0] U_WEEK  = "W";
    localparam logic [7:0] U_YEAR  = "Y";
    localparam logic [7:0] L_SEC   = "s";
    localparam logic [7:0] L_MIN   = "m";
    localparam logic [7:0] L_HOUR  = "h";
    localparam logic [7:0] L_DAY   = "d";
    localparam logic [7:0] L_WEEK  = "w";

    // Seconds per unit; magnitude saturation point
    localparam longint unsigned SAT_MAG = 64'h1_0000_0000;
    localparam longint unsigned N_MIN   = 60;
    localparam longint unsigned N_HOUR  = 3600;
    localparam longint unsigned N_DAY   = 86400;
    localparam longint unsigned N_WEEK  = 604800;
    localparam longint unsigned N_MONTH = 2678400;
    localparam longint unsigned N_YEAR  = 31536000;

    // Predicted parse state
    logic            dur_form;
    logic [1:0]      pfx_stage;
    logic            neg_lead;
    logic            time_sect;
    logic            num_neg;
    logic            have_sign;
    logic            have_digit;
    logic            num_bad;
    longint unsigned magnitude;
    logic [5:0]      body_len;

    interval_t expected_q [$];

    function void clear_parse();
        pfx_stage  = 2'd0;
        neg_lead   = 1'b0;
        time_sect  = 1'b0;
        num_neg    = 1'b0;
        have_sign  = 1'b0;
        have_digit = 1'b0;
        num_bad    = 1'b0;
        magnitude  = 0;
        body_len   = 6'd0;
    endfunction

    // Decimal number: one optional sign, then digits
    function void take_number(input logic [7:0] ch);
        if (ch >= C_0 && ch <= C_9)
        begin
            magnitude  = magnitude * 10 + 64'(ch - C_0);
            if (magnitude > SAT_MAG)
                magnitude = SAT_MAG;
            have_digit = 1'b1;
        end
        else if (ch == C_PLUS || ch == C_MINUS)
        begin
            if (have_digit || have_sign)
                num_bad = 1'b1;
            else
            begin
                have_sign = 1'b1;
                num_neg   = (ch == C_MINUS);
            end
        end
        else
            num_bad = 1'b1;
    endfunction

    // Character ahead of the unit; duration form strips '-', 'P', 'T' first
    function void take_body(input logic [7:0] ch);
        if (body_len != 6'd63)
            body_len = body_len + 6'd1;
        if (dur_form)
        begin
            if (pfx_stage == 2'd0)
            begin
                pfx_stage = 2'd1;
                if (ch == C_MINUS)
                begin
                    neg_lead = 1'b1;
                    return;
                end
            end
            if (pfx_stage == 2'd1)
            begin
                pfx_stage = 2'd2;
                if (ch == C_P)
                    return;
            end
            if (pfx_stage == 2'd2)
            begin
                pfx_stage = 2'd3;
                if (ch == C_T)
                begin
                    time_sect = 1'b1;
                    return;
                end
            end
        end
        take_number(ch);
    endfunction

    // Final character: unit lookup, then bad unit > too long > bad number > range
    function interval_t finish_string(input logic [7:0] ch);
        interval_t       r;
        longint unsigned scale;
        longint unsigned prod;
        longint unsigned limit;
        logic            approx;
        logic            bad_unit;
        logic            neg;
        scale     = 1;
        approx    = 1'b0;
        bad_unit  = 1'b0;
        r.seconds = 32'sd0;
        if (ch >= C_0 && ch <= C_9)
            take_body(ch);
        else if (!dur_form)
        begin
            case (ch)
                L_SEC:   scale = 1;
                L_MIN:   scale = N_MIN;
                L_HOUR:  scale = N_HOUR;
                L_DAY:   scale = N_DAY;
                L_WEEK:  scale = N_WEEK;
                default: bad_unit = 1'b1;
            endcase
        end
        else
        begin
            case (ch)
                U_SEC:   scale = 1;
                U_MIN:
                begin
                    scale  = time_sect ? N_MIN : N_MONTH;
                    approx = !time_sect;
                end
                U_HOUR:  scale = N_HOUR;
                U_DAY:   scale = N_DAY;
                U_WEEK:  scale = N_WEEK;
                U_YEAR:
                begin
                    scale  = N_YEAR;
                    approx = 1'b1;
                end
                default: bad_unit = 1'b1;
            endcase
        end

        if (bad_unit)
            r.status = ST_BAD_UNIT;
        else if (int'(body_len) > BUFFER_BYTES - 1)
            r.status = ST_RANGE;
        else if (num_bad || !have_digit)
            r.status = ST_BAD_NUM;
        else
        begin
            neg   = neg_lead ^ num_neg;
            prod  = magnitude * scale;
            limit = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            if (prod > limit)
                r.status = ST_RANGE;
            else
            begin
                r.seconds = neg ? 32'(32'd0 - prod[31:0]) : prod[31:0];
                r.status  = approx ? ST_APPROX : ST_OK;
            end
        end
        clear_parse();
        return r;
    endfunction

    // Predict on accepted characters, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        interval_t want;
        if (!rst_n)
        begin
            dur_form = 1'b0;
            clear_parse();
            expected_q.delete();
            mismatches = 0;
            compared   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                dur_form = cfg.duration_mode;

            if (chars.valid && chars.ready)
            begin
                if (chars.is_last)
                    expected_q.push_back(finish_string(chars.text_char));
                else
                    take_body(chars.text_char);
            end

            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, got seconds %0d status %0d",
                             $time, res.seconds, res.status);
                end
                else
                begin
                    want = expected_q.pop_front();
                    compared++;
                    if (res.seconds !== want.seconds)
                    begin
                        mismatches++;
                        $display("%0t: seconds mismatch, expected %0d, got %0d",
                                 $time, want.seconds, res.seconds);
                    end
                    if (res.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, res.status);
                    end
                end
            end
        end
        in_flight <= expected_q.size();
    end

endmodule

// File: verif/tb_duration_string_parser_unit.sv
`timescale 1ns / 1ps

module tb_duration_string_parser_unit;

    import dsp_pkg::*;

    typedef logic [7:0] char_q_t [$];

    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SEGMENT_BEATS  = 120;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 24;

    localparam logic [7:0] K_ZERO  = "0";
    localparam logic [7:0] K_PLUS  = "+";
    localparam logic [7:0] K_MINUS = "-";
    localparam logic [7:0] K_P     = "P";
    localparam logic [7:0] K_T     = "T";

    logic clk = 1'b0;
    logic rst_n;

    int unsigned mismatches;
    int unsigned in_flight;
    int unsigned compared;
    int unsigned beats_sent;
    int unsigned strings_sent;
    int unsigned quiet_cycles;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_off;

    dsp_char_if char_if ();
    dsp_res_if  res_if ();
    dsp_cfg_if  cfg_if ();

    duration_string_parser_unit #(
        .BUFFER_BYTES (32)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_if),
        .result  (res_if),
        .cfg     (cfg_if)
    );

    interval_checker #(
        .BUFFER_BYTES (32)
    ) u_interval_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (char_if),
        .res        (res_if),
        .cfg        (cfg_if),
        .mismatches (mismatches),
        .in_flight  (in_flight),
        .compared   (compared)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result ready: random stalls, or one long hold-off on request
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (char_if.valid && char_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // One character beat, with random idle ahead of it
    task automatic send_beat(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            char_if.valid <= 1'b0;
            @(posedge clk);
        end
        char_if.valid     <= 1'b1;
        char_if.text_char <= ch;
        char_if.is_last   <= last;
        do @(posedge clk); while (!char_if.ready);
        beats_sent++;
        if (last)
            strings_sent++;
    endtask

    task automatic send_chars(input char_q_t q);
        for (int i = 0; i < q.size(); i++)
            send_beat(q[i], i == q.size() - 1);
    endtask

    function automatic char_q_t to_chars(input string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    task automatic send_text(input string s);
        send_chars(to_chars(s));
    endtask

    function automatic string zeros(input int n);
        string s;
        s = "";
        repeat (n) s = {s, "0"};
        return s;
    endfunction

    // Stop offering, wait for every predicted result, then let the pipe settle
    task automatic wait_drained(input int settle);
        char_if.valid <= 1'b0;
        do @(posedge clk); while (in_flight != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_mode(input bit dur_form);
        wait_drained(SETTLE_CYCLES);
        cfg_if.valid         <= 1'b1;
        cfg_if.duration_mode <= dur_form;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly well-formed strings with random content, some broken, some noise
    function automatic char_q_t random_interval(input bit dur_form);
        char_q_t         q;
        string           units;
        string           digits;
        longint unsigned scale;
        longint unsigned mag;
        logic [7:0]      unit_ch;
        bit              in_time;
        int              pick;
        int              u;
        pick    = $urandom_range(99);
        in_time = 1'b0;
        scale   = 1;
        if (pick >= 88)
        begin
            repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
            return q;
        end

        if (dur_form)
        begin
            if ($urandom_range(2) == 0)
                q.push_back(K_MINUS);
            if ($urandom_range(3) != 0)
                q.push_back(K_P);
            if ($urandom_range(1) == 0)
            begin
                q.push_back(K_T);
                in_time = 1'b1;
            end
        end

        // Unit choice; now and then a unit of the other form
        units = dur_form ? "SMHDWY" : "smhdw";
        if ($urandom_range(19) == 0)
            units = dur_form ? "smhdw" : "SMHDWY";
        u = $urandom_range(0, units.len());
        unit_ch = 8'd0;
        if (u < units.len())
        begin
            unit_ch = units[u];
            case (u)
                0:       scale = 1;
                1:       scale = (dur_form && !in_time) ? 2678400 : 60;
                2:       scale = 3600;
                3:       scale = 86400;
                4:       scale = 604800;
                default: scale = 31536000;
            endcase
        end

        case ($urandom_range(5))
            0:       q.push_back(K_PLUS);
            1:       q.push_back(K_MINUS);
            default: ;
        endcase

        // Magnitude: mostly small, some near the signed 32-bit edge, some huge
        case ($urandom_range(9))
            0, 1, 2, 3, 4: mag = $urandom_range(0, 999);
            5, 6:          mag = $urandom_range(0, 99999);
            7:             mag = $urandom();
            8:             mag = 64'h8000_0000 / scale + $urandom_range(0, 2) - 1;
            default:       mag = {$urandom(), $urandom()};
        endcase
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 35)) q.push_back(K_ZERO);
        digits = $sformatf("%0d", mag);
        for (int i = 0; i < digits.len(); i++)
            q.push_back(digits[i]);
        if (u < units.len())
            q.push_back(unit_ch);

        // Broken variants
        if (pick >= 70)
        begin
            case ($urandom_range(3))
                0: q.insert($urandom_range(0, q.size()), 8'($urandom_range(1, 255)));
                1:
                begin
                    if (q.size() > 1)
                        q.delete($urandom_range(0, q.size() - 1));
                end
                2: q[q.size() - 1] = 8'($urandom_range(0, 255));
                default: q.insert($urandom_range(0, q.size() - 1), K_MINUS);
            endcase
        end
        return q;
    endfunction

    task automatic run_segment(input bit dur_form);
        int unsigned start;
        start = beats_sent;
        while (beats_sent - start < SEGMENT_BEATS)
            send_chars(random_interval(dur_form));
    endtask

    // Stimulus and verdict
    initial
    begin
        rst_n                 = 1'b0;
        hold_off              = 1'b0;
        beats_sent            = 0;
        strings_sent          = 0;
        tx_idle_pct           = 33;
        rx_idle_pct           = 54;
        char_if.valid        <= 1'b0;
        char_if.text_char    <= 8'd0;
        char_if.is_last      <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.duration_mode <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain form: range edges, every unit, saturation, bad number and unit,
        // length limit, byte extremes
        set_mode(1'b0);
        send_text("0");
        send_text("2147483647");
        send_text("-2147483648");
        send_text("2147483648");
        send_text("+15m");
        send_text("3h");
        send_text("2d");
        send_text("1w");
        send_text("-35791394m");
        send_text("35791395m");
        send_text("99999999999s");
        send_text("s");
        send_text("+-5s");
        send_text("5 s");
        send_text("1x");
        send_text("7S");
        send_text({zeros(30), "1s"});
        send_text({zeros(31), "1s"});
        send_text({zeros(70), "5"});
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);

        // Duration form: prefixes, month vs minute, approximate units,
        // sign cancel, prefix letter as the unit
        set_mode(1'b1);
        send_text("P1Y");
        send_text("P2M");
        send_text("PT2M");
        send_text("-P-5S");
        send_text("-PT3H");
        send_text("P1W");
        send_text("P4D");
        send_text("T5M");
        send_text("P");
        send_text("PT");
        send_text("P-");
        send_text("P5s");
        send_text("P69Y");
        send_text("-P68Y");
        send_text("PT-2147483648S");

        // Random part: three idle mixes, both forms each
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
            rx_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;
            for (int m = 0; m < 2; m++)
            begin
                set_mode(m[0]);
                if (phase == 2 && m == 0)
                    hold_off = 1'b1;
                run_segment(m[0]);
            end
        end
        set_mode(1'b0);
        run_segment(1'b0);

        wait_drained(TAIL_CYCLES);
        $display("summary: %0d characters in %0d strings, plain and duration forms",
                 beats_sent, strings_sent);
        $display("summary: %0d results compared, including a long result back-pressure stretch",
                 compared);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
